// File: rtl/zud_pkg.sv
// package for the zero-delimited unstuffing deframer
// holds the receive mode type, status codes, escape codes and the result struct
// no dependencies
package zud_pkg;

   // default limit on raw bytes in one frame
   localparam int unsigned MAX_FRAME_DEF = 512;

   // escape byte and its two partner codes
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ESC  = 8'h01;
   localparam logic [7:0] BYTE_ESC2 = 8'h02;

   // frame status codes
   localparam logic [1:0] ST_GOOD       = 2'd0;
   localparam logic [1:0] ST_MALFORMED  = 2'd1;
   localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;
   localparam logic [1:0] ST_TOO_LONG   = 2'd3;

   // receive mode, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE      = 5'b00001,
      MODE_DATA      = 5'b00010,
      MODE_ONE_ZERO  = 5'b00100,
      MODE_DROP      = 5'b01000,
      MODE_DROP_ZERO = 5'b10000
   } mode_type;

   // framing state apart from the byte counter
   typedef struct packed {
      mode_type mode;
      logic     esc_pending;
   } rx_state_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      logic [1:0] frame_status;
   } result_type;

endpackage

// File: rtl/zero_delimited_unstuffing_deframer.sv
// top level of the zero-delimited unstuffing deframer
// holds the framing state and the result register; depends on zud_pkg, zud_step
//
// usage:
//  - req channel carries one raw byte of the stuffed stream per item
//  - rsp channel carries at most one result per byte: either a decoded
//    payload byte (byte_valid) or a frame end marker with its status
//  - a frame is kept by the receiver only if its end marker says good
//  - each result is registered and shows on rsp in the cycle after acceptance
//  - throughput: one byte per cycle unless a full result register is stalled;
//    the single result register is refilled in the same cycle it is emptied
//  - a stalled receiver holds the result register; req_ready drops only
//    while that register is full and rsp_ready is low
//  - bytes that give no result (zeros while idle, escapes, dropped bytes)
//    are still accepted and advance the framing state
//  - reset returns the block to idle with no result pending
module zero_delimited_unstuffing_deframer #(
   parameter int unsigned MAX_FRAME = zud_pkg::MAX_FRAME_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_frame_status
);
   import zud_pkg::*;

   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   rx_state_type  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          out_valid_ff, out_valid_in;
   result_type    result_ff, result_in;
   rx_state_type  step_state;
   logic [CW-1:0] step_count;
   logic          step_emit;
   result_type    step_result;
   logic          accept;

   // handshake
   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // per-byte decisions
   zud_step #(
      .MAX_FRAME (MAX_FRAME),
      .CW        (CW)
   ) u_step (
      .cur_state (state_ff),
      .cur_count (count_ff),
      .rx_byte   (req_rx_byte),
      .nxt_state (step_state),
      .nxt_count (step_count),
      .emit      (step_emit),
      .result    (step_result)
   );

   // next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (accept) begin
         state_in = step_state;
         count_in = step_count;
         if (step_emit) begin
            out_valid_in = 1'b1;
            result_in    = step_result;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_IDLE;
         state_ff.esc_pending <= 1'b0;
         count_ff             <= '0;
         out_valid_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = result_ff.out_byte;
   assign rsp_byte_valid   = result_ff.byte_valid;
   assign rsp_frame_end    = result_ff.frame_end;
   assign rsp_frame_status = result_ff.frame_status;

endmodule

// File: rtl/zud_step.sv
// per-byte decision logic of the deframer: next state and optional result
// combinational only; depends on zud_pkg
module zud_step #(
   parameter int unsigned MAX_FRAME = zud_pkg::MAX_FRAME_DEF,
   parameter int unsigned CW        = $clog2(MAX_FRAME + 1)
) (
   input  zud_pkg::rx_state_type cur_state,
   input  logic [CW-1:0]         cur_count,
   input  logic [7:0]            rx_byte,
   output zud_pkg::rx_state_type nxt_state,
   output logic [CW-1:0]         nxt_count,
   output logic                  emit,
   output zud_pkg::result_type   result
);
   import zud_pkg::*;

   localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME);

   logic          is_zero;
   logic [CW-1:0] cnt_inc;
   logic          bad_esc;

   assign is_zero = (rx_byte == BYTE_ZERO);
   assign cnt_inc = cur_count + CW'(1);

   always_comb begin
      nxt_state = cur_state;
      nxt_count = cur_count;
      emit      = 1'b0;
      result    = '0;
      bad_esc   = 1'b0;
      unique case (cur_state.mode)
         // inside a frame: unstuff and watch the length
         MODE_DATA: begin
            nxt_count = cnt_inc;
            if (is_zero) begin
               nxt_state.mode = MODE_ONE_ZERO;
            end else if (cur_state.esc_pending) begin
               nxt_state.esc_pending = 1'b0;
               if (rx_byte == BYTE_ESC) begin
                  emit              = 1'b1;
                  result.byte_valid = 1'b1;
                  result.out_byte   = BYTE_ZERO;
               end else if (rx_byte == BYTE_ESC2) begin
                  emit              = 1'b1;
                  result.byte_valid = 1'b1;
                  result.out_byte   = BYTE_ESC;
               end else begin
                  bad_esc = 1'b1;
               end
            end else if (rx_byte == BYTE_ESC) begin
               nxt_state.esc_pending = 1'b1;
            end else begin
               emit              = 1'b1;
               result.byte_valid = 1'b1;
               result.out_byte   = rx_byte;
            end
            // faults override any payload byte
            if (bad_esc) begin
               nxt_state.mode        = MODE_DROP;
               nxt_state.esc_pending = 1'b0;
               nxt_count             = '0;
               emit                  = 1'b1;
               result                = '0;
               result.frame_end      = 1'b1;
               result.frame_status   = ST_BAD_ESCAPE;
            end else if (cnt_inc >= MAX_C) begin
               nxt_state.mode        = is_zero ? MODE_DROP_ZERO : MODE_DROP;
               nxt_state.esc_pending = 1'b0;
               nxt_count             = '0;
               emit                  = 1'b1;
               result                = '0;
               result.frame_end      = 1'b1;
               result.frame_status   = ST_TOO_LONG;
            end
         end
         // one zero seen: a second closes, anything else is malformed
         MODE_ONE_ZERO: begin
            emit                  = 1'b1;
            result.frame_end      = 1'b1;
            nxt_state.esc_pending = 1'b0;
            nxt_count             = '0;
            if (is_zero) begin
               nxt_state.mode      = MODE_IDLE;
               result.frame_status = cur_state.esc_pending ? ST_BAD_ESCAPE : ST_GOOD;
            end else begin
               nxt_state.mode      = MODE_DROP;
               result.frame_status = ST_MALFORMED;
            end
         end
         // dropping until a zero pair
         MODE_DROP: begin
            if (is_zero) begin
               nxt_state.mode = MODE_DROP_ZERO;
            end
         end
         MODE_DROP_ZERO: begin
            nxt_state.mode = is_zero ? MODE_IDLE : MODE_DROP;
         end
         // idle: a nonzero byte opens a frame
         default: begin
            nxt_state.esc_pending = 1'b0;
            nxt_count             = '0;
            nxt_state.mode        = MODE_IDLE;
            if (!is_zero) begin
               nxt_state.mode = MODE_DATA;
               nxt_count      = CW'(1);
               if (rx_byte == BYTE_ESC) begin
                  nxt_state.esc_pending = 1'b1;
               end else begin
                  emit              = 1'b1;
                  result.byte_valid = 1'b1;
                  result.out_byte   = rx_byte;
               end
            end
         end
      endcase
   end

endmodule

// File: rtl/zud_checker.sv
// port-level checks for the deframer, attached by bind
// depends on the top level's ports and on zud_pkg for the status and byte codes
module zud_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_frame_end,
   input logic [1:0] rsp_frame_status
);
   import zud_pkg::*;

   // a pending result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // every result is either a payload byte or a frame end, never both
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_valid != rsp_frame_end))
      else $error("result kind not exclusive");

   // payload bytes carry no status, end markers carry no byte
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_byte_valid && rsp_frame_status == ST_GOOD) ||
                     (rsp_frame_end && rsp_out_byte == BYTE_ZERO)))
      else $error("stray bits in result");

   // a new result follows an accepted item
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an item");

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind zero_delimited_unstuffing_deframer zud_checker u_zud_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_frame_status (rsp_frame_status)
);
